/* sv/spwm_pkg.sv */
// ----------------------------------------------------------------------------
// spwm_pkg
// Shared constants, register indexes and types for the soft PWM block with
// debounced key polling.
// ----------------------------------------------------------------------------
`default_nettype none

package spwm_pkg;

  // Tick dividers
  localparam int PWM_STEPS   = 40;
  localparam int POLL_DIVIDE = 200;

  localparam int STEP_W = $clog2(PWM_STEPS);
  localparam int POLL_W = (POLL_DIVIDE > 1) ? $clog2(POLL_DIVIDE) : 1;

  // Field and register widths
  localparam int DUTY_W     = 7;
  localparam int DEB_W      = 16;
  localparam int TIME_W     = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register reset values
  localparam int DUTY_MAX = 100;
  localparam int DUTY_RST = 10;
  localparam int DEB_RST  = 200;

  // Threshold = duty*PWM_STEPS/100, taken as a multiply by a scaled
  // reciprocal of 100; the error stays below a hundredth of an LSB, so the
  // floor matches exact division for every duty up to 100 and PWM_STEPS up
  // to 255.
  localparam int THR_W     = $clog2(PWM_STEPS + 1);
  localparam int THR_SHIFT = 22;
  localparam int THR_RECIP = ((1 << THR_SHIFT) + DUTY_MAX - 1) / DUTY_MAX;
  localparam int THR_MUL   = PWM_STEPS * THR_RECIP;
  localparam int MUL_W     = THR_SHIFT + THR_W + 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DUTY     = 2'd0,
    REG_DEBOUNCE = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic [DEB_W-1:0] debounce;
  } spwm_cfg_t;

endpackage

`default_nettype wire

/* sv/spwm_in_if.sv */
// ----------------------------------------------------------------------------
// spwm_in_if
// Tick request channel: key levels and millisecond timestamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface spwm_in_if;
  logic        valid;
  logic        ready;
  logic        key_a_level;
  logic        key_b_level;
  logic [31:0] now_ms;

  modport source (output valid, key_a_level, key_b_level, now_ms, input ready);
  modport sink   (input valid, key_a_level, key_b_level, now_ms, output ready);
endinterface

`default_nettype wire

/* sv/spwm_out_if.sv */
// ----------------------------------------------------------------------------
// spwm_out_if
// Result channel: PWM level and debounced key press pulses.
// ----------------------------------------------------------------------------
`default_nettype none

interface spwm_out_if;
  logic valid;
  logic ready;
  logic pwm_level;
  logic key_a_press;
  logic key_b_press;

  modport source (output valid, pwm_level, key_a_press, key_b_press, input ready);
  modport sink   (input valid, pwm_level, key_a_press, key_b_press, output ready);
endinterface

`default_nettype wire

/* sv/spwm_cfg.sv */
// ----------------------------------------------------------------------------
// spwm_cfg
// Configuration registers; derives the PWM on-threshold from the duty.
// ----------------------------------------------------------------------------
`default_nettype none

module spwm_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [spwm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [spwm_pkg::CFG_DATA_W-1:0] cfg_data,
  output spwm_pkg::spwm_cfg_t                  cfg
);
  import spwm_pkg::*;

  logic [DUTY_W-1:0] duty_r;
  logic [DEB_W-1:0]  debounce_r;
  logic [DUTY_W-1:0] duty_sat;
  logic [MUL_W-1:0]  thr_prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r     <= DUTY_W'(DUTY_RST);
      debounce_r <= DEB_W'(DEB_RST);
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_DUTY:     duty_r     <= cfg_data[DUTY_W-1:0];
        REG_DEBOUNCE: debounce_r <= cfg_data[DEB_W-1:0];
        default:      ;
      endcase
    end
  end

  // Saturate duty above one hundred percent
  assign duty_sat = (duty_r > DUTY_W'(DUTY_MAX)) ? DUTY_W'(DUTY_MAX) : duty_r;
  assign thr_prod = MUL_W'(duty_sat) * MUL_W'(THR_MUL);

  assign cfg.threshold = thr_prod[THR_SHIFT +: THR_W];
  assign cfg.debounce  = debounce_r;

endmodule

`default_nettype wire

/* sv/spwm_key.sv */
// ----------------------------------------------------------------------------
// spwm_key
// One polled key: rising-edge detect with a debounce window on the
// timestamp of the last accepted press.
// ----------------------------------------------------------------------------
`default_nettype none

module spwm_key (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        sample,
  input  wire logic                        level,
  input  wire logic [spwm_pkg::TIME_W-1:0] now_ms,
  input  wire logic [spwm_pkg::DEB_W-1:0]  debounce,
  output logic                             press
);
  import spwm_pkg::*;

  logic              prev_r;
  logic [TIME_W-1:0] last_r;
  logic [TIME_W-1:0] elapsed;

  // Modular distance since the last accepted press
  assign elapsed = now_ms - last_r;
  assign press   = sample && level && !prev_r && (elapsed > TIME_W'(debounce));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= 1'b0;
      last_r <= '0;
    end else if (sample) begin
      prev_r <= level;
      if (press) begin
        last_r <= now_ms;
      end
    end
  end

endmodule

`default_nettype wire

/* sv/soft_pwm_with_key_debounce.sv */
// ----------------------------------------------------------------------------
// soft_pwm_with_key_debounce
// Timer-tick driven software-style PWM with two polled, debounced keys.
//
//   channel | dir | payload                                  | handshake
//   --------+-----+------------------------------------------+------------
//   in_ch   | in  | key_a_level, key_b_level, now_ms[31:0]   | valid/ready
//   out_ch  | out | pwm_level, key_a_press, key_b_press      | valid/ready
//   cfg_*   | in  | cfg_idx[1:0], cfg_data[15:0]             | cfg_we
//
// One tick request per cycle unless a stalled result holds it back; each
// request passes through the input register, then the result register.
// The tick counters and key state advance as a request moves from the input
// register into the result register.
// A stalled result holds; the input register still takes a request when the
// result register drains in the same cycle.
// Synchronous active-low reset empties both stages and restores registers.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_pwm_with_key_debounce (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  spwm_in_if.sink                              in_ch,
  spwm_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [spwm_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [spwm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import spwm_pkg::*;

  spwm_cfg_t cfg;

  // Input stage
  logic              s1_valid_r;
  logic              s1_key_a_r;
  logic              s1_key_b_r;
  logic [TIME_W-1:0] s1_now_r;

  // Tick state
  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic [POLL_W-1:0] poll_r;
  logic [POLL_W-1:0] poll_nxt;
  logic              poll_hit;

  // Result stage
  logic out_valid_r;
  logic out_pwm_r;
  logic out_key_a_r;
  logic out_key_b_r;

  logic out_free;
  logic advance;
  logic take;
  logic pwm_nxt;
  logic press_a;
  logic press_b;

  spwm_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  assign out_free = !out_valid_r || out_ch.ready;
  assign advance  = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign take     = in_ch.valid && in_ch.ready;

  assign step_nxt = (step_r == STEP_W'(PWM_STEPS - 1)) ? '0 : step_r + 1'b1;
  assign poll_hit = (poll_r == POLL_W'(POLL_DIVIDE - 1));
  assign poll_nxt = poll_hit ? '0 : poll_r + 1'b1;
  assign pwm_nxt  = (cfg.threshold != '0) && (THR_W'(step_nxt) < cfg.threshold);

  spwm_key u_key_a (
    .clk      (clk),
    .rst_n    (rst_n),
    .sample   (advance && poll_hit),
    .level    (s1_key_a_r),
    .now_ms   (s1_now_r),
    .debounce (cfg.debounce),
    .press    (press_a)
  );

  spwm_key u_key_b (
    .clk      (clk),
    .rst_n    (rst_n),
    .sample   (advance && poll_hit),
    .level    (s1_key_b_r),
    .now_ms   (s1_now_r),
    .debounce (cfg.debounce),
    .press    (press_b)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (take) begin
      s1_valid_r <= 1'b1;
    end else if (advance) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_key_a_r <= in_ch.key_a_level;
      s1_key_b_r <= in_ch.key_b_level;
      s1_now_r   <= in_ch.now_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      poll_r <= '0;
    end else if (advance) begin
      step_r <= step_nxt;
      poll_r <= poll_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_pwm_r   <= pwm_nxt;
      out_key_a_r <= press_a;
      out_key_b_r <= press_b;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pwm_level   = out_pwm_r;
  assign out_ch.key_a_press = out_key_a_r;
  assign out_ch.key_b_press = out_key_b_r;

endmodule

`default_nettype wire

/* sv/spwm_checker.sv */
// ----------------------------------------------------------------------------
// spwm_checker
// Port-level checks for soft_pwm_with_key_debounce, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module spwm_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic pwm_level,
  input wire logic key_a_press,
  input wire logic key_b_press
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(pwm_level)
      && $stable(key_a_press) && $stable(key_b_press))
    else $error("stalled result changed");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A new result follows a taken request
  a_rise_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result without a request");

  // A draining result never blocks the input side
  a_ready_through: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while result side drains");

endmodule

bind soft_pwm_with_key_debounce spwm_checker u_spwm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .pwm_level   (out_ch.pwm_level),
  .key_a_press (out_ch.key_a_press),
  .key_b_press (out_ch.key_b_press)
);

`default_nettype wire

/* dv/soft_pwm_with_key_debounce_tb.sv */
// ----------------------------------------------------------------------------
// soft_pwm_with_key_debounce_tb
// Self-checking bench for the soft PWM block with polled key debounce.
// Timer-tick requests go in through a queue-fed driver. Each accepted request
// runs through a cycle-free model of the PWM counter, the key poll divider and
// the two debounce trackers. Every taken result is checked field by field
// against the oldest predicted tick. The run is split into phases that each
// end on a key poll tick. The duty and debounce registers change between
// phases. The poll tick's timestamp mostly sits around the debounce boundary.
// ----------------------------------------------------------------------------
`default_nettype none

module soft_pwm_with_key_debounce_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spwm_pkg::*;

  localparam int RESET_CYCLES = 12;
  localparam int N_PHASES     = 7;
  localparam int N_DIRECTED   = 25;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_CAP   = 40;

  // Indexes outside the register map; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  typedef struct packed {
    logic              key_a_level;
    logic              key_b_level;
    logic [TIME_W-1:0] now_ms;
  } tick_req_t;

  typedef struct packed {
    logic pwm_level;
    logic key_a_press;
    logic key_b_press;
  } tick_res_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  spwm_in_if  in_ch ();
  spwm_out_if out_ch ();

  soft_pwm_with_key_debounce i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Shadow registers and tick state of the block
  logic [DUTY_W-1:0] duty_reg     = DUTY_W'(DUTY_RST);
  logic [DEB_W-1:0]  debounce_reg = DEB_W'(DEB_RST);
  int                pwm_step     = 0;
  int                poll_count   = 0;
  logic              key_a_prev   = 1'b0;
  logic              key_b_prev   = 1'b0;
  logic [TIME_W-1:0] key_a_last   = '0;
  logic [TIME_W-1:0] key_b_last   = '0;

  tick_req_t pending_ticks[$];
  tick_res_t expected_ticks[$];
  int        ticks_queued   = 0;
  int        results_seen   = 0;
  int        mismatch_count = 0;
  bit        bursts_on      = 1'b1;
  int        in_gap         = 0;
  int        out_stall      = 0;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < REPORT_CAP) begin
      $display("ERROR @%0t: %s", $realtime, msg);
    end
    mismatch_count++;
  endtask

  function automatic logic press_accepted(input logic level, input logic prev,
                                          input logic [TIME_W-1:0] last,
                                          input logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] since;
    since = now - last;
    return level && !prev && (since > TIME_W'(debounce_reg));
  endfunction

  // Advance the tick state by one request and return the PWM level and key pulses.
  function automatic tick_res_t pwm_key_tick(input tick_req_t req);
    tick_res_t res;
    int        duty;
    int        threshold;
    res      = '0;
    duty     = (int'(duty_reg) > DUTY_MAX) ? DUTY_MAX : int'(duty_reg);
    pwm_step = (pwm_step == PWM_STEPS - 1) ? 0 : pwm_step + 1;
    threshold = duty * PWM_STEPS / DUTY_MAX;
    res.pwm_level = (threshold > 0) && (pwm_step < threshold);
    if (poll_count == POLL_DIVIDE - 1) begin
      poll_count = 0;
      res.key_a_press = press_accepted(req.key_a_level, key_a_prev, key_a_last, req.now_ms);
      res.key_b_press = press_accepted(req.key_b_level, key_b_prev, key_b_last, req.now_ms);
      if (res.key_a_press) key_a_last = req.now_ms;
      if (res.key_b_press) key_b_last = req.now_ms;
      // prev follows the sampled level even when the edge is dropped
      key_a_prev = req.key_a_level;
      key_b_prev = req.key_b_level;
    end else begin
      poll_count++;
    end
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_DUTY:     duty_reg = data[DUTY_W-1:0];
      REG_DEBOUNCE: debounce_reg = data[DEB_W-1:0];
      default: ;
    endcase
  endtask

  task automatic queue_tick(input logic ka, input logic kb, input logic [TIME_W-1:0] now);
    tick_req_t req;
    req.key_a_level = ka;
    req.key_b_level = kb;
    req.now_ms      = now;
    pending_ticks.push_back(req);
    ticks_queued++;
  endtask

  function automatic logic poll_level(input logic prev);
    // mostly press a released key; a held key releases half the time
    return prev ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 3) != 0);
  endfunction

  // Queue random ticks up to and including the next key poll tick. Key state
  // only moves on poll ticks, so the shadow state is current here.
  task automatic fill_to_next_poll();
    logic [TIME_W-1:0] base;
    logic [TIME_W-1:0] now;
    do begin
      if ((ticks_queued + 1) % POLL_DIVIDE == 0) begin
        base = $urandom_range(0, 1) ? key_a_last : key_b_last;
        case ($urandom_range(0, 5))
          0: now = base + TIME_W'(debounce_reg);          // exactly at the limit: drop
          1: now = base + TIME_W'(debounce_reg) + 32'd1;  // first accepted time
          2: now = base;
          3: now = base - 32'd1;                          // wraps to a huge gap
          4: now = base + TIME_W'($urandom_range(0, 2 * int'(debounce_reg) + 2));
          default: now = $urandom();
        endcase
        queue_tick(poll_level(key_a_prev), poll_level(key_b_prev), now);
      end else begin
        queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
      end
    end while (ticks_queued % POLL_DIVIDE != 0);
  endtask

  // Hold until every queued request is taken and every result has come back.
  task automatic drain_ticks();
    int waited;
    waited = 0;
    while ((pending_ticks.size() != 0 || in_ch.valid || expected_ticks.size() != 0)
           && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    if (expected_ticks.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_ticks.size()));
      expected_ticks.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Tick request driver
  always @(posedge clk) begin
    tick_req_t nxt_req;
    logic      nxt_valid;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_gap = 0;
    end else if (!in_ch.valid || in_ch.ready === 1'b1) begin
      nxt_valid = 1'b0;
      // idle payload is noise; the block must not take it
      nxt_req   = {1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom()};
      if (in_gap > 0) begin
        in_gap--;
      end else if (pending_ticks.size() != 0) begin
        if (bursts_on && $urandom_range(0, 9) == 0) begin
          in_gap = $urandom_range(0, 14);
        end else begin
          nxt_req   = pending_ticks.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_ch.valid       <= nxt_valid;
      in_ch.key_a_level <= nxt_req.key_a_level;
      in_ch.key_b_level <= nxt_req.key_b_level;
      in_ch.now_ms      <= nxt_req.now_ms;
    end
  end

  // Result side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      out_stall = 0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else if (bursts_on && $urandom_range(0, 9) == 0) begin
      out_stall = $urandom_range(0, 14);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Predict on every taken tick, check on every taken result
  always @(posedge clk) begin
    tick_req_t got_req;
    tick_res_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready === 1'b1) begin
        got_req = {in_ch.key_a_level, in_ch.key_b_level, in_ch.now_ms};
        expected_ticks.push_back(pwm_key_tick(got_req));
      end
      if (out_ch.valid === 1'b1 && out_ch.ready) begin
        if (expected_ticks.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
        end else begin
          want = expected_ticks.pop_front();
          if (out_ch.pwm_level !== want.pwm_level)
            report_mismatch($sformatf("result %0d pwm_level got %b want %b",
                                      results_seen, out_ch.pwm_level, want.pwm_level));
          if (out_ch.key_a_press !== want.key_a_press)
            report_mismatch($sformatf("result %0d key_a_press got %b want %b",
                                      results_seen, out_ch.key_a_press, want.key_a_press));
          if (out_ch.key_b_press !== want.key_b_press)
            report_mismatch($sformatf("result %0d key_b_press got %b want %b",
                                      results_seen, out_ch.key_b_press, want.key_b_press));
        end
        results_seen++;
      end
    end
  end

  initial begin
    int duty_plan [N_PHASES];
    int deb_plan  [N_PHASES];
    logic [CFG_DATA_W-1:0] data;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = REG_DUTY;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.key_a_level = 1'b0;
    in_ch.key_b_level = 1'b0;
    in_ch.now_ms      = '0;
    out_ch.ready      = 1'b0;

    duty_plan = '{0, 127, 2, 100, 101, 3, 0};
    deb_plan  = '{0, 65535, 200, 1, 65535, 0, 0};
    duty_plan[N_PHASES-1] = $urandom_range(0, 127);
    deb_plan[N_PHASES-2]  = $urandom_range(0, 65535);
    deb_plan[N_PHASES-1]  = $urandom_range(0, 400);

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Unmapped indexes: reset duty and debounce must survive
    write_reg(REG_SPARE_2, '1);
    write_reg(REG_SPARE_3, '1);
    @(negedge clk);

    // Field extremes under reset settings
    queue_tick(1'b0, 1'b0, 32'h0000_0000);
    queue_tick(1'b1, 1'b1, 32'hFFFF_FFFF);
    queue_tick(1'b1, 1'b0, 32'h0000_0000);
    queue_tick(1'b0, 1'b1, 32'hFFFF_FFFF);
    queue_tick(1'b1, 1'b1, 32'hAAAA_AAAA);
    queue_tick(1'b0, 1'b0, 32'h5555_5555);
    while (ticks_queued < N_DIRECTED)
      queue_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom());
    drain_ticks();

    for (int p = 0; p < N_PHASES; p++) begin
      data = CFG_DATA_W'($urandom());
      data[DUTY_W-1:0] = DUTY_W'(duty_plan[p]);
      write_reg(REG_DUTY, data);
      write_reg(REG_DEBOUNCE, CFG_DATA_W'(deb_plan[p]));
      if (p == 2) write_reg(REG_SPARE_3, CFG_DATA_W'($urandom()));
      @(negedge clk);
      bursts_on = (p != 3) && (p != N_PHASES - 1);
      fill_to_next_poll();
      drain_ticks();
    end

    repeat (8) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("soft_pwm_with_key_debounce_tb: PASS");
    end else begin
      $display("soft_pwm_with_key_debounce_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("soft_pwm_with_key_debounce_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire

/* soft_pwm_with_key_debounce.f */
sv/spwm_pkg.sv
sv/spwm_in_if.sv
sv/spwm_out_if.sv
sv/spwm_cfg.sv
sv/spwm_key.sv
sv/soft_pwm_with_key_debounce.sv
sv/spwm_checker.sv
dv/soft_pwm_with_key_debounce_tb.sv
